FILE: design/lcdseq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_pkg: shared types and constants of the LCD bus sequencer
// Command codes, job and transfer records, wait times and the power-up table.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_INSTR  = 2'd1,
    CMD_DATA   = 2'd2,
    CMD_CURSOR = 2'd3
  } cmd_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_t;

  localparam logic [15:0] WAIT_SETTLE  = 16'd100;
  localparam logic [15:0] WAIT_LONG    = 16'd2000;
  localparam logic [15:0] WAIT_WAKE_1  = 16'd4500;
  localparam logic [15:0] WAIT_WAKE_2  = 16'd150;
  localparam logic [15:0] WAIT_POWERUP = 16'd50000;

  localparam logic [7:0] INSTR_CLEAR  = 8'h01;
  localparam logic [7:0] INSTR_HOME   = 8'h02;
  localparam logic [7:0] DDRAM_SET    = 8'h80;

  localparam int STEP_W = 4;

  // One queued unit of work for the back end
  typedef struct packed {
    logic       is_init;
    logic       mode8;
    logic [7:0] data;
    logic       rs;
    logic       long_wait;
  } job_t;

  // One bus transfer
  typedef struct packed {
    logic [7:0]  bus_value;
    logic        register_select;
    logic        strobe;
    logic [15:0] wait_us;
    logic        last;
  } xfer_t;

  function automatic xfer_t mk_xfer(logic [7:0] bus, logic strobe,
                                    logic [15:0] wait_us, logic last);
    xfer_t x;
    x.bus_value       = bus;
    x.register_select = 1'b0;
    x.strobe          = strobe;
    x.wait_us         = wait_us;
    x.last            = last;
    return x;
  endfunction

  // Power-up sequence, four-bit and eight-bit forms
  function automatic xfer_t init_xfer(logic mode8, logic [STEP_W-1:0] step);
    xfer_t x;
    x = mk_xfer(8'h00, 1'b0, WAIT_POWERUP, 1'b0);
    if (mode8) begin
      unique case (step)
        4'd0:    x = mk_xfer(8'h00, 1'b0, WAIT_POWERUP, 1'b0);
        4'd1:    x = mk_xfer(8'h38, 1'b1, WAIT_WAKE_1, 1'b0);
        4'd2:    x = mk_xfer(8'h38, 1'b1, WAIT_WAKE_2, 1'b0);
        4'd3:    x = mk_xfer(8'h38, 1'b1, WAIT_SETTLE, 1'b0);
        4'd4:    x = mk_xfer(8'h38, 1'b1, WAIT_SETTLE, 1'b0);
        4'd5:    x = mk_xfer(8'h0C, 1'b1, WAIT_SETTLE, 1'b0);
        4'd6:    x = mk_xfer(8'h01, 1'b1, WAIT_LONG, 1'b0);
        default: x = mk_xfer(8'h06, 1'b1, WAIT_SETTLE, 1'b1);
      endcase
    end else begin
      unique case (step)
        4'd0:    x = mk_xfer(8'h00, 1'b0, WAIT_POWERUP, 1'b0);
        4'd1:    x = mk_xfer(8'h03, 1'b1, WAIT_WAKE_1, 1'b0);
        4'd2:    x = mk_xfer(8'h03, 1'b1, WAIT_WAKE_1, 1'b0);
        4'd3:    x = mk_xfer(8'h03, 1'b1, WAIT_WAKE_2, 1'b0);
        4'd4:    x = mk_xfer(8'h02, 1'b1, WAIT_SETTLE, 1'b0);
        4'd5:    x = mk_xfer(8'h02, 1'b1, WAIT_SETTLE, 1'b0);
        4'd6:    x = mk_xfer(8'h08, 1'b1, WAIT_SETTLE, 1'b0);
        4'd7:    x = mk_xfer(8'h00, 1'b1, WAIT_SETTLE, 1'b0);
        4'd8:    x = mk_xfer(8'h0C, 1'b1, WAIT_SETTLE, 1'b0);
        4'd9:    x = mk_xfer(8'h00, 1'b1, WAIT_SETTLE, 1'b0);
        4'd10:   x = mk_xfer(8'h01, 1'b1, WAIT_LONG, 1'b0);
        4'd11:   x = mk_xfer(8'h00, 1'b1, WAIT_SETTLE, 1'b0);
        default: x = mk_xfer(8'h06, 1'b1, WAIT_SETTLE, 1'b1);
      endcase
    end
    return x;
  endfunction

endpackage
`default_nettype wire

FILE: design/lcdseq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_front: command intake and classification
// Holds the bus width register and turns each command into one job.
// ----------------------------------------------------------------------------
module lcdseq_front #(
  parameter int ROW_OFFSET = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_bus_width_mode,
  input  wire logic [1:0]        command,
  input  wire logic [7:0]        value,
  input  wire logic [5:0]        column,
  input  wire logic [1:0]        line,
  output lcdseq_pkg::job_t       job
);
  import lcdseq_pkg::*;

  localparam logic [7:0] ROW_OFF8 = 8'(ROW_OFFSET);

  logic       mode_r;
  logic       row;
  logic [7:0] addr;
  cmd_t       cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_bus_width_mode;
    end
  end

  // clamp rows two and three to row one
  assign row  = (line != 2'd0);
  assign addr = DDRAM_SET | (8'(column) + (row ? ROW_OFF8 : 8'd0));
  assign cmd  = cmd_t'(command);

  always_comb begin
    job.mode8     = mode_r;
    job.is_init   = 1'b0;
    job.data      = value;
    job.rs        = 1'b0;
    job.long_wait = 1'b0;
    unique case (cmd)
      CMD_INIT: begin
        job.is_init = 1'b1;
      end
      CMD_INSTR: begin
        job.long_wait = (value == INSTR_CLEAR) || (value == INSTR_HOME);
      end
      CMD_DATA: begin
        job.rs = 1'b1;
      end
      default: begin
        job.data = addr;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/lcdseq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_fifo: two-entry job queue
// Decouples command intake from transfer generation.
// ----------------------------------------------------------------------------
module lcdseq_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire lcdseq_pkg::job_t  wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output lcdseq_pkg::job_t       rd_data,
  output logic                   empty
);
  import lcdseq_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_wr;
  logic       do_rd;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: design/lcdseq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_back: transfer generator
// Expands queued jobs into bus transfers into an output register, one per cycle unless pop stalls it.
// ----------------------------------------------------------------------------
module lcdseq_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lcdseq_pkg::job_t  q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output lcdseq_pkg::xfer_t      xfer_out
);
  import lcdseq_pkg::*;

  seq_state_t        state_r;
  seq_state_t        state_nxt;
  job_t              cur_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  xfer_t             out_xfer_r;
  xfer_t             xfer;
  logic              adv;
  logic              emit;
  logic [15:0]       final_wait;

  assign adv        = !out_valid_r || pop;
  assign final_wait = cur_r.long_wait ? WAIT_LONG : WAIT_SETTLE;

  // transfer for the current step
  always_comb begin
    xfer = init_xfer(cur_r.mode8, step_r);
    if (!cur_r.is_init) begin
      xfer.register_select = cur_r.rs;
      xfer.strobe          = 1'b1;
      if (cur_r.mode8) begin
        xfer.bus_value = cur_r.data;
        xfer.wait_us   = final_wait;
        xfer.last      = 1'b1;
      end else if (step_r == '0) begin
        xfer.bus_value = {4'h0, cur_r.data[7:4]};
        xfer.wait_us   = WAIT_SETTLE;
        xfer.last      = 1'b0;
      end else begin
        xfer.bus_value = {4'h0, cur_r.data[3:0]};
        xfer.wait_us   = final_wait;
        xfer.last      = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (!q_empty) begin
          state_nxt = SEQ_RUN;
        end
      end
      default: begin
        if (adv && xfer.last && q_empty) begin
          state_nxt = SEQ_IDLE;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    emit  = 1'b0;
    q_pop = 1'b0;
    unique case (state_r)
      SEQ_IDLE: begin
        q_pop = !q_empty;
      end
      default: begin
        emit  = adv;
        q_pop = adv && xfer.last && !q_empty;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        step_r <= '0;
      end else if (emit) begin
        step_r <= step_r + 1'b1;
      end
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (emit) begin
      out_xfer_r <= xfer;
    end
  end

  assign empty    = !out_valid_r;
  assign xfer_out = out_xfer_r;

endmodule
`default_nettype wire

FILE: design/char_lcd_bus_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer: bus transfer sequencer for a character LCD
// Expands host commands into timed data-line transfers.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): one item is a command (initialize, instruction
//   byte, data byte, set cursor) with its value, column and line fields.
//   Result queue (empty/pop): one item per bus transfer: data-line value,
//   register select, enable strobe flag, wait in microseconds and a last
//   flag on the final transfer of a command.
//   Config channel (cfg_valid/cfg_ready): bus width mode, 0 four-bit,
//   1 eight-bit; always ready, write it only while the block is idle.
// Timing:
//   A command enters a two-entry job queue at the edge that accepts it. The
//   generator loads the job into its job register and emits one transfer per
//   cycle into the output register unless a held output stalls it. A byte
//   command yields 1 or 2 transfers, initialize 8 or 13. Queued jobs run
//   back to back, one transfer/cycle while pop keeps the output moving.
// Reset clears the queues and sets four-bit mode. When pop stays low the
// output register holds, the generator stalls, and full rises once the
// job queue fills.
module char_lcd_bus_sequencer #(
  parameter int ROW_OFFSET = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_bus_width_mode,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_value,
  input  wire logic [5:0]  in_column,
  input  wire logic [1:0]  in_line,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_bus_value,
  output logic             out_register_select,
  output logic             out_strobe_res,
  output logic [15:0]      out_wait_us,
  output logic             out_last
);
  import lcdseq_pkg::*;

  job_t  job;
  job_t  q_data;
  logic  q_empty;
  logic  q_pop;
  xfer_t xfer;

  // config is taken every cycle
  assign cfg_ready = 1'b1;

  lcdseq_front #(
    .ROW_OFFSET (ROW_OFFSET)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_bus_width_mode (cfg_bus_width_mode),
    .command            (in_command),
    .value              (in_value),
    .column             (in_column),
    .line               (in_line),
    .job                (job)
  );

  // job queue: push lands here directly, full backs up the host
  lcdseq_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (job),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  lcdseq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .xfer_out (xfer)
  );

  assign out_bus_value       = xfer.bus_value;
  assign out_register_select = xfer.register_select;
  assign out_strobe_res      = xfer.strobe;
  assign out_wait_us         = xfer.wait_us;
  assign out_last            = xfer.last;

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the character LCD bus sequencer
// Drives host commands through the push/full queue, predicts every bus
// transfer in both bus widths, or takes it from a directed row, and checks each popped item in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lcdseq_pkg::*;

  localparam int ROW_STEP    = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_TAIL   = 8;
  localparam int MAX_GAP     = 10;

  // Power-up and fixed instruction bytes of the init sequence
  localparam logic [7:0] FN_SET_8BIT = 8'h38;
  localparam logic [7:0] FN_SET_4BIT = 8'h28;
  localparam logic [7:0] WAKE_NIB    = 8'h03;
  localparam logic [7:0] GO_4BIT_NIB = 8'h02;
  localparam logic [7:0] DISPLAY_ON  = 8'h0C;
  localparam logic [7:0] ENTRY_MODE  = 8'h06;

  typedef struct packed {
    logic [7:0]  bus;
    logic        rs;
    logic        strobe;
    logic [15:0] wait_us;
    logic        last;
  } transfer_t;

  // One command row; n_typed > 0 means the expected transfers are given
  // directly instead of coming from the predictor.
  typedef struct {
    logic       mode;
    cmd_t       cmd;
    logic [7:0] value;
    logic [5:0] column;
    logic [1:0] ln;
    int         n_typed;
    transfer_t  t0;
    transfer_t  t1;
  } cmd_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_bus_width_mode;
  logic        push;
  logic        full;
  logic [1:0]  in_command;
  logic [7:0]  in_value;
  logic [5:0]  in_column;
  logic [1:0]  in_line;
  logic        empty;
  logic        pop;
  logic [7:0]  out_bus_value;
  logic        out_register_select;
  logic        out_strobe_res;
  logic [15:0] out_wait_us;
  logic        out_last;

  transfer_t   pending_xfers[$];
  cmd_row_t    directed_rows[$];
  logic        width_mode;
  logic        no_stall;
  int          fail_count;
  int          cycle_count;
  int          cmds_sent;
  int          inits_sent;
  int          xfers_checked;
  int          mode_writes;

  char_lcd_bus_sequencer #(.ROW_OFFSET(ROW_STEP)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_bus_width_mode (cfg_bus_width_mode),
    .push               (push),
    .full               (full),
    .in_command         (in_command),
    .in_value           (in_value),
    .in_column          (in_column),
    .in_line            (in_line),
    .empty              (empty),
    .pop                (pop),
    .out_bus_value      (out_bus_value),
    .out_register_select(out_register_select),
    .out_strobe_res     (out_strobe_res),
    .out_wait_us        (out_wait_us),
    .out_last           (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Transfer predictor
  // ---------------------------------------------------------------------------
  function automatic transfer_t xf(logic [7:0] bus, logic rs, logic strobe,
                                   logic [15:0] wait_us, logic last);
    transfer_t t;
    t.bus     = bus;
    t.rs      = rs;
    t.strobe  = strobe;
    t.wait_us = wait_us;
    t.last    = last;
    return t;
  endfunction

  function automatic void add_xfer(logic [7:0] bus, logic rs, logic strobe,
                                   logic [15:0] wait_us);
    pending_xfers.push_back(xf(bus, rs, strobe, wait_us, 1'b0));
  endfunction

  // One byte: a single transfer in eight-bit mode, high then low nibble
  // otherwise. Only the low nibble carries the final wait.
  function automatic void add_byte(logic [7:0] b, logic rs, logic [15:0] wait_us);
    if (width_mode) begin
      add_xfer(b, rs, 1'b1, wait_us);
    end else begin
      add_xfer({4'h0, b[7:4]}, rs, 1'b1, WAIT_SETTLE);
      add_xfer({4'h0, b[3:0]}, rs, 1'b1, wait_us);
    end
  endfunction

  function automatic void predict_transfers(cmd_t c, logic [7:0] v, logic [5:0] col,
                                            logic [1:0] ln);
    logic       row;
    logic [7:0] addr;
    transfer_t  t;
    case (c)
      CMD_INIT: begin
        add_xfer(8'h00, 1'b0, 1'b0, WAIT_POWERUP);
        if (width_mode) begin
          add_xfer(FN_SET_8BIT, 1'b0, 1'b1, WAIT_WAKE_1);
          add_xfer(FN_SET_8BIT, 1'b0, 1'b1, WAIT_WAKE_2);
          add_xfer(FN_SET_8BIT, 1'b0, 1'b1, WAIT_SETTLE);
          add_byte(FN_SET_8BIT, 1'b0, WAIT_SETTLE);
        end else begin
          add_xfer(WAKE_NIB, 1'b0, 1'b1, WAIT_WAKE_1);
          add_xfer(WAKE_NIB, 1'b0, 1'b1, WAIT_WAKE_1);
          add_xfer(WAKE_NIB, 1'b0, 1'b1, WAIT_WAKE_2);
          add_xfer(GO_4BIT_NIB, 1'b0, 1'b1, WAIT_SETTLE);
          add_byte(FN_SET_4BIT, 1'b0, WAIT_SETTLE);
        end
        add_byte(DISPLAY_ON, 1'b0, WAIT_SETTLE);
        add_byte(INSTR_CLEAR, 1'b0, WAIT_LONG);
        add_byte(ENTRY_MODE, 1'b0, WAIT_SETTLE);
      end
      CMD_INSTR: begin
        add_byte(v, 1'b0, (v == INSTR_CLEAR || v == INSTR_HOME) ? WAIT_LONG : WAIT_SETTLE);
      end
      CMD_DATA: begin
        add_byte(v, 1'b1, WAIT_SETTLE);
      end
      default: begin
        // Rows 2 and 3 fold onto row 1; an oversize column just adds in
        row  = (ln >= 2'd2) ? 1'b1 : ln[0];
        addr = DDRAM_SET | ({2'b00, col} + (row ? ROW_STEP[7:0] : 8'd0));
        add_byte(addr, 1'b0, WAIT_SETTLE);
      end
    endcase
    t = pending_xfers.pop_back();
    t.last = 1'b1;
    pending_xfers.push_back(t);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_row(logic mode, cmd_t c, logic [7:0] v, logic [5:0] col,
                                  logic [1:0] ln, int n_typed, transfer_t t0,
                                  transfer_t t1);
    cmd_row_t r;
    r.mode    = mode;
    r.cmd     = c;
    r.value   = v;
    r.column  = col;
    r.ln      = ln;
    r.n_typed = n_typed;
    r.t0      = t0;
    r.t1      = t1;
    directed_rows.push_back(r);
  endfunction

  function automatic cmd_row_t random_row(logic mode);
    cmd_row_t r;
    r.mode    = mode;
    r.n_typed = 0;
    r.t0      = '0;
    r.t1      = '0;
    // Keep init rare: it fans out into up to 13 transfers
    if ($urandom_range(0, 99) < 8)
      r.cmd = CMD_INIT;
    else
      r.cmd = cmd_t'($urandom_range(1, 3));
    r.value = 8'($urandom());
    if (r.cmd == CMD_INSTR && $urandom_range(0, 9) == 0)
      r.value = $urandom_range(0, 1) ? INSTR_CLEAR : INSTR_HOME;
    if ($urandom_range(0, 99) < 85)
      r.column = 6'($urandom_range(0, 39));
    else
      r.column = 6'($urandom_range(40, 63));
    r.ln = 2'($urandom_range(0, 3));
    return r;
  endfunction

  // Offer one command; called and returns at a falling edge. Keep push high
  // across items when the drawn gap is zero.
  task automatic send_command(cmd_row_t r);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command <= r.cmd;
    in_value   <= r.value;
    in_column  <= r.column;
    in_line    <= r.ln;
    push       <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    // Accepted at this edge: log what it must produce
    if (r.n_typed == 0) begin
      predict_transfers(r.cmd, r.value, r.column, r.ln);
    end else begin
      pending_xfers.push_back(r.t0);
      if (r.n_typed > 1) pending_xfers.push_back(r.t1);
    end
    cmds_sent++;
    if (r.cmd == CMD_INIT) inits_sent++;
    @(negedge clk);
  endtask

  // Drop push and hold until every expected transfer has been popped,
  // then let the pipeline settle.
  task automatic drain_block();
    push <= 1'b0;
    do @(negedge clk); while (pending_xfers.size() != 0);
    repeat (IDLE_TAIL) @(negedge clk);
  endtask

  // Write the bus width register; only called with the block idle
  task automatic write_width_mode(logic mode);
    cfg_bus_width_mode <= mode;
    cfg_valid          <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_mode = mode;
    mode_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop with random back-pressure and check each item in order
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    int        gap;
    transfer_t want;
    pop = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      xfers_checked++;
      if (pending_xfers.size() == 0) begin
        fail_count++;
        $display({"%0t: unexpected transfer, expected none, ",
                  "actual bus=%0h rs=%0b en=%0b wait=%0d last=%0b"},
                 $time, out_bus_value, out_register_select, out_strobe_res, out_wait_us,
                 out_last);
      end else begin
        want = pending_xfers.pop_front();
        compare_field("bus_value", want.bus, out_bus_value);
        compare_field("register_select", want.rs, out_register_select);
        compare_field("strobe_res", want.strobe, out_strobe_res);
        compare_field("wait_us", want.wait_us, out_wait_us);
        compare_field("last", want.last, out_last);
      end
      @(negedge clk);
    end
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d transfers still expected",
             $time, cycle_count, pending_xfers.size());
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cmd_row_t r;
    int       ph;
    int       k;

    rst_n              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_bus_width_mode = 1'b0;
    push               = 1'b0;
    in_command         = CMD_INIT;
    in_value           = 8'h00;
    in_column          = 6'd0;
    in_line            = 2'd0;
    width_mode         = 1'b0;
    no_stall           = 1'b0;
    fail_count         = 0;
    cmds_sent          = 0;
    inits_sent         = 0;
    xfers_checked      = 0;
    mode_writes        = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows. The first ones run in the reset width (four-bit) with
    // no register write, so they also check the reset value.
    add_row(1'b0, CMD_INSTR, INSTR_CLEAR, 6'd0, 2'd0, 2,
            xf(8'h00, 1'b0, 1'b1, WAIT_SETTLE, 1'b0), xf(8'h01, 1'b0, 1'b1, WAIT_LONG, 1'b1));
    add_row(1'b0, CMD_INIT, 8'h00, 6'd0, 2'd0, 0, '0, '0);
    add_row(1'b0, CMD_DATA, 8'hFF, 6'd63, 2'd3, 2,
            xf(8'h0F, 1'b1, 1'b1, WAIT_SETTLE, 1'b0), xf(8'h0F, 1'b1, 1'b1, WAIT_SETTLE, 1'b1));
    add_row(1'b0, CMD_DATA, 8'h00, 6'd0, 2'd0, 2,
            xf(8'h00, 1'b1, 1'b1, WAIT_SETTLE, 1'b0), xf(8'h00, 1'b1, 1'b1, WAIT_SETTLE, 1'b1));
    add_row(1'b0, CMD_INSTR, INSTR_HOME, 6'd0, 2'd0, 0, '0, '0);
    add_row(1'b0, CMD_INSTR, 8'h03, 6'd0, 2'd0, 0, '0, '0);
    add_row(1'b0, CMD_INSTR, 8'hFF, 6'd0, 2'd0, 0, '0, '0);
    add_row(1'b0, CMD_CURSOR, 8'hFF, 6'd0, 2'd0, 2,
            xf(8'h08, 1'b0, 1'b1, WAIT_SETTLE, 1'b0), xf(8'h00, 1'b0, 1'b1, WAIT_SETTLE, 1'b1));
    // Row 3 folds onto row 1
    add_row(1'b0, CMD_CURSOR, 8'h00, 6'd0, 2'd3, 2,
            xf(8'h0C, 1'b0, 1'b1, WAIT_SETTLE, 1'b0), xf(8'h00, 1'b0, 1'b1, WAIT_SETTLE, 1'b1));
    add_row(1'b0, CMD_CURSOR, 8'h00, 6'd39, 2'd1, 0, '0, '0);
    add_row(1'b0, CMD_CURSOR, 8'h00, 6'd63, 2'd0, 0, '0, '0);
    add_row(1'b0, CMD_CURSOR, 8'h00, 6'd63, 2'd2, 0, '0, '0);
    // Eight-bit width
    add_row(1'b1, CMD_INIT, 8'h00, 6'd0, 2'd0, 0, '0, '0);
    add_row(1'b1, CMD_INSTR, INSTR_CLEAR, 6'd0, 2'd0, 1,
            xf(8'h01, 1'b0, 1'b1, WAIT_LONG, 1'b1), '0);
    add_row(1'b1, CMD_INSTR, INSTR_HOME, 6'd0, 2'd0, 1,
            xf(8'h02, 1'b0, 1'b1, WAIT_LONG, 1'b1), '0);
    add_row(1'b1, CMD_INSTR, 8'h00, 6'd0, 2'd0, 1,
            xf(8'h00, 1'b0, 1'b1, WAIT_SETTLE, 1'b1), '0);
    add_row(1'b1, CMD_DATA, 8'hFF, 6'd0, 2'd0, 1,
            xf(8'hFF, 1'b1, 1'b1, WAIT_SETTLE, 1'b1), '0);
    add_row(1'b1, CMD_DATA, 8'hA5, 6'd21, 2'd1, 0, '0, '0);
    add_row(1'b1, CMD_DATA, 8'h5A, 6'd42, 2'd2, 0, '0, '0);
    add_row(1'b1, CMD_CURSOR, 8'h00, 6'd0, 2'd0, 1,
            xf(8'h80, 1'b0, 1'b1, WAIT_SETTLE, 1'b1), '0);
    add_row(1'b1, CMD_CURSOR, 8'h00, 6'd39, 2'd1, 0, '0, '0);
    add_row(1'b1, CMD_CURSOR, 8'h00, 6'd63, 2'd3, 0, '0, '0);
    // Back to four-bit
    add_row(1'b0, CMD_INIT, 8'h00, 6'd0, 2'd0, 0, '0, '0);
    add_row(1'b0, CMD_INSTR, 8'h80, 6'd0, 2'd0, 0, '0, '0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != width_mode) begin
        drain_block();
        write_width_mode(directed_rows[i].mode);
      end
      send_command(directed_rows[i]);
    end

    // Random phases: alternate the width, run some phases with no idling
    // on either side so the block sees back-to-back traffic.
    for (ph = 0; ph < 6; ph++) begin
      drain_block();
      write_width_mode(ph[0] ? 1'b0 : 1'b1);
      no_stall = (ph == 2 || ph == 5);
      for (k = 0; k < 33; k++) begin
        r = random_row(width_mode);
        send_command(r);
      end
    end

    // Drop push, wait out every expected transfer plus a quiet tail
    drain_block();
    no_stall = 1'b0;
    repeat (4 * IDLE_TAIL) @(negedge clk);
    if (pending_xfers.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected transfers never arrived", $time, pending_xfers.size());
    end

    $display("Ran %0d commands (%0d power-up inits) in both bus widths, %0d width writes;",
             cmds_sent, inits_sent, mode_writes);
    $display("checked %0d bus transfers in %0d cycles, %0d mismatches.",
             xfers_checked, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
